[rtl/mieu_pkg.sv]
// ----------------------------------------------------------------------------
// mieu_pkg
// Operation codes, memory request codes and shared types of the execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;
  localparam logic [5:0] OP_NOP = 6'd0, OP_ADD = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3,
    OP_ADDU = 6'd4, OP_AND = 6'd5, OP_ANDI = 6'd6, OP_BEQ = 6'd7, OP_BGEZ = 6'd8,
    OP_BGTZ = 6'd9, OP_BLEZ = 6'd10, OP_BLTZ = 6'd11, OP_BNE = 6'd12, OP_BREAK = 6'd13,
    OP_DIV = 6'd14, OP_J = 6'd15, OP_JAL = 6'd16, OP_JALR = 6'd17, OP_JR = 6'd18,
    OP_LB = 6'd19, OP_LBU = 6'd20, OP_LUI = 6'd21, OP_LW = 6'd22, OP_MFHI = 6'd23,
    OP_MFLO = 6'd24, OP_MULT = 6'd25, OP_OR = 6'd26, OP_ORI = 6'd27, OP_SB = 6'd28,
    OP_SEB = 6'd29, OP_SLL = 6'd30, OP_SLT = 6'd31, OP_SLTI = 6'd32, OP_SLTIU = 6'd33,
    OP_SLTU = 6'd34, OP_SRA = 6'd35, OP_SRL = 6'd36, OP_SUB = 6'd37, OP_SUBU = 6'd38,
    OP_SW = 6'd39, OP_XOR = 6'd40, OP_LDRET = 6'd41;

  localparam logic [2:0] MEM_NONE = 3'd0, MEM_RB = 3'd1, MEM_RW = 3'd2,
    MEM_WB = 3'd3, MEM_WW = 3'd4;
  localparam logic [1:0] ST_DONE = 2'd0, ST_OVF = 2'd1, ST_BRK = 2'd2;
  localparam logic [1:0] LK_NONE = 2'd0, LK_LB = 2'd1, LK_LBU = 2'd2, LK_LW = 2'd3;
  localparam logic [31:0] PC_TOP_MASK = 32'hF000_0000;

  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  // Item as it leaves the front end.
  typedef struct packed {
    logic [5:0]  func;
    logic [4:0]  rs_index;
    logic [4:0]  rt_index;
    logic [4:0]  rd_index;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [25:0] jump_target;
    logic [31:0] pc;
    logic [31:0] load_data;
    logic        is_muldiv;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        redirect;
    logic [31:0] redirect_target;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
  } result_t;
endpackage

[rtl/mieu_front.sv]
// ----------------------------------------------------------------------------
// mieu_front
// Accepts instruction words, tags multiply/divide, and queues them.
// ----------------------------------------------------------------------------
module mieu_front import mieu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);
  item_t mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0] count;
  logic push, pop;
  item_t in_word;

  assign in_ready = count != (QAW+1)'(QDEPTH);
  assign q_valid = count != '0;
  assign q_item = mem[rptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    in_word = in_item;
    in_word.is_muldiv = in_item.func == OP_MULT || in_item.func == OP_DIV;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_word;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule

[rtl/mieu_muldiv.sv]
// ----------------------------------------------------------------------------
// mieu_muldiv
// Iterative signed multiply (shift-add) and divide (restoring), one bit a cycle.
// ----------------------------------------------------------------------------
module mieu_muldiv import mieu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_div,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic        done,
  output logic        wr_en,
  output logic [31:0] hi_out,
  output logic [31:0] lo_out
);
  logic [5:0] cnt;
  logic op_div, neg_q, neg_r, skip;
  logic [63:0] acc;
  logic [31:0] mcand, ua, ub;
  logic [32:0] trial;

  assign ua = a[31] ? 32'd0 - a : a;
  assign ub = b[31] ? 32'd0 - b : b;
  // multiply: acc = {partial, multiplier}; divide: acc = {remainder, quotient}
  assign trial = {acc[63:31]} - {1'b0, mcand};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op_div <= is_div;
        skip <= is_div && b == 32'd0;
        neg_q <= a[31] ^ b[31];
        neg_r <= a[31];
        cnt <= 6'd32;
        if (is_div) begin
          acc <= {32'd0, ua};
          mcand <= ub;
        end else begin
          acc <= {32'd0, b};
          mcand <= a;
        end
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
          if (op_div) begin
            if (!trial[32]) acc <= {trial[31:0], acc[30:0], 1'b1};
            else acc <= {acc[62:0], 1'b0};
          end else begin
            // signed multiply: subtract on the sign bit step (last)
            logic [32:0] part;
            part = {acc[63], acc[63:32]};
            if (acc[0]) begin
              if (cnt == 6'd1) part = part - {mcand[31], mcand};
              else part = part + {mcand[31], mcand};
            end
            acc <= {part, acc[31:1]};
          end
        end
      end
    end
  end

  assign wr_en = done && !(op_div && skip);
  always_comb begin
    if (op_div) begin
      lo_out = neg_q ? 32'd0 - acc[31:0] : acc[31:0];
      hi_out = neg_r ? 32'd0 - acc[63:32] : acc[63:32];
    end else begin
      lo_out = acc[31:0];
      hi_out = acc[63:32];
    end
  end
endmodule

[rtl/mieu_back.sv]
// ----------------------------------------------------------------------------
// mieu_back
// Executes queued words against the register file and HI/LO; holds the result.
// ----------------------------------------------------------------------------
module mieu_back import mieu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);
  logic [31:0] rf [32];
  logic [31:0] hi, lo;
  logic [4:0] pld;
  logic [1:0] plk;
  logic md_busy, md_done, md_wr, md_start;
  logic [31:0] md_hi, md_lo;
  logic [31:0] a, b, simm, s, wval;
  logic [4:0] widx;
  logic wen, take, ovf;
  result_t res;
  logic [1:0] plk_next;
  logic [4:0] pld_next;

  // free when no result is held (or it leaves now) and mult/div is idle
  logic can_go;
  assign can_go = (!out_valid || out_ready) && !md_busy && !md_done;
  assign q_ready = can_go && !(q_item.is_muldiv && 1'b0);
  assign md_start = q_valid && q_ready && q_item.is_muldiv;

  assign a = q_item.rs_index == 5'd0 ? 32'd0 : rf[q_item.rs_index];
  assign b = q_item.rt_index == 5'd0 ? 32'd0 : rf[q_item.rt_index];
  assign simm = {{16{q_item.immediate[15]}}, q_item.immediate};

  mieu_muldiv u_md (
    .clk, .rst, .start(md_start), .is_div(q_item.func == OP_DIV), .a, .b,
    .busy(md_busy), .done(md_done), .wr_en(md_wr), .hi_out(md_hi), .lo_out(md_lo)
  );

  always_comb begin
    res = '0;
    wen = 1'b0;
    widx = q_item.rd_index;
    wval = '0;
    take = 1'b0;
    s = '0;
    ovf = 1'b0;
    plk_next = plk;
    pld_next = pld;
    case (q_item.func)
      OP_ADD: begin
        s = a + b; ovf = (a[31] ~^ b[31]) && (s[31] != a[31]);
        wen = !ovf; wval = s;
      end
      OP_ADDI: begin
        s = a + simm; ovf = (a[31] ~^ simm[31]) && (s[31] != a[31]);
        wen = !ovf; wval = s; widx = q_item.rt_index;
      end
      OP_ADDIU: begin wen = 1'b1; wval = a + simm; widx = q_item.rt_index; end
      OP_ADDU: begin wen = 1'b1; wval = a + b; end
      OP_AND: begin wen = 1'b1; wval = a & b; end
      OP_ANDI: begin wen = 1'b1; wval = a & {16'd0, q_item.immediate};
        widx = q_item.rt_index; end
      OP_BEQ: take = a == b;
      OP_BGEZ: take = !a[31];
      OP_BGTZ: take = !a[31] && a != 32'd0;
      OP_BLEZ: take = a[31] || a == 32'd0;
      OP_BLTZ: take = a[31];
      OP_BNE: take = a != b;
      OP_BREAK: res.status = ST_BRK;
      OP_J, OP_JAL: begin
        res.redirect = 1'b1;
        res.redirect_target = ((q_item.pc + 32'd4) & PC_TOP_MASK)
                              | {4'd0, q_item.jump_target, 2'b00};
        wen = q_item.func == OP_JAL; widx = 5'd31; wval = q_item.pc + 32'd8;
      end
      OP_JALR: begin res.redirect = 1'b1; res.redirect_target = a;
        wen = 1'b1; wval = q_item.pc + 32'd8; end
      OP_JR: begin res.redirect = 1'b1; res.redirect_target = a; end
      OP_LB, OP_LBU, OP_LW: begin
        res.mem_op = q_item.func == OP_LW ? MEM_RW : MEM_RB;
        res.mem_address = a + simm;
        pld_next = q_item.rt_index;
        plk_next = q_item.func == OP_LB ? LK_LB : q_item.func == OP_LBU ? LK_LBU : LK_LW;
      end
      OP_LUI: begin wen = 1'b1; wval = {q_item.immediate, 16'd0};
        widx = q_item.rt_index; end
      OP_MFHI: begin wen = 1'b1; wval = hi; end
      OP_MFLO: begin wen = 1'b1; wval = lo; end
      OP_OR: begin wen = 1'b1; wval = a | b; end
      OP_ORI: begin wen = 1'b1; wval = a | {16'd0, q_item.immediate};
        widx = q_item.rt_index; end
      OP_SB: begin res.mem_op = MEM_WB; res.mem_address = a + simm;
        res.mem_write_data = {24'd0, b[7:0]}; end
      OP_SEB: begin wen = 1'b1; wval = {{24{b[7]}}, b[7:0]}; end
      OP_SLL: begin wen = 1'b1; wval = b << q_item.shift_amount; end
      OP_SLT: begin wen = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
      OP_SLTI: begin wen = 1'b1; wval = {31'd0, $signed(a) < $signed(simm)};
        widx = q_item.rt_index; end
      OP_SLTIU: begin wen = 1'b1; wval = {31'd0, a < simm}; widx = q_item.rt_index; end
      OP_SLTU: begin wen = 1'b1; wval = {31'd0, a < b}; end
      OP_SRA: begin wen = 1'b1; wval = $unsigned($signed(b) >>> q_item.shift_amount); end
      OP_SRL: begin wen = 1'b1; wval = b >> q_item.shift_amount; end
      OP_SUB: begin
        s = a - b; ovf = (a[31] ^ b[31]) && (s[31] != a[31]);
        wen = !ovf; wval = s;
      end
      OP_SUBU: begin wen = 1'b1; wval = a - b; end
      OP_SW: begin res.mem_op = MEM_WW; res.mem_address = a + simm;
        res.mem_write_data = b; end
      OP_XOR: begin wen = 1'b1; wval = a ^ b; end
      OP_LDRET: begin
        widx = pld; wen = plk != LK_NONE;
        case (plk)
          LK_LB: wval = {{24{q_item.load_data[7]}}, q_item.load_data[7:0]};
          LK_LBU: wval = {24'd0, q_item.load_data[7:0]};
          default: wval = q_item.load_data;
        endcase
        plk_next = LK_NONE; pld_next = 5'd0;
      end
      default: ;
    endcase
    if (ovf) res.status = ST_OVF;
    if (take) begin
      res.redirect = 1'b1;
      res.redirect_target = q_item.pc + 32'd4 + {simm[29:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) rf[i] <= '0;
      hi <= '0;
      lo <= '0;
      pld <= '0;
      plk <= LK_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (md_wr) begin
        hi <= md_hi;
        lo <= md_lo;
      end
      if (md_done) begin
        out_valid <= 1'b1;
        out_res <= '0;
      end
      if (q_valid && q_ready && !q_item.is_muldiv) begin
        if (wen && widx != 5'd0) rf[widx] <= wval;
        pld <= pld_next;
        plk <= plk_next;
        out_res <= res;
        out_valid <= 1'b1;
      end
    end
  end
endmodule

[rtl/mips_integer_execute_unit.sv]
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// MIPS32 integer execute unit: front queue plus execute back end.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. Each word passes through the
// two-entry front queue and then the back end, which for most operations
// executes and registers the result in the same cycle. MULT and DIV run in a
// one-bit-per-cycle shift unit; while they run the back end holds, and the
// front queue keeps accepting until it is full.
module mips_integer_execute_unit import mieu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  func,
  input  logic [4:0]  rs_index,
  input  logic [4:0]  rt_index,
  input  logic [4:0]  rd_index,
  input  logic [4:0]  shift_amount,
  input  logic [15:0] immediate,
  input  logic [25:0] jump_target,
  input  logic [31:0] pc,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        redirect,
  output logic [31:0] redirect_target,
  output logic [2:0]  mem_op,
  output logic [31:0] mem_address,
  output logic [31:0] mem_write_data
);
  item_t in_item, q_item;
  logic q_valid, q_ready;
  result_t res;

  always_comb begin
    in_item = '0;
    in_item.func = func;
    in_item.rs_index = rs_index;
    in_item.rt_index = rt_index;
    in_item.rd_index = rd_index;
    in_item.shift_amount = shift_amount;
    in_item.immediate = immediate;
    in_item.jump_target = jump_target;
    in_item.pc = pc;
    in_item.load_data = load_data;
  end

  mieu_front u_front (.clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item);
  mieu_back u_back (.clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_res(res));

  assign status = res.status;
  assign redirect = res.redirect;
  assign redirect_target = res.redirect_target;
  assign mem_op = res.mem_op;
  assign mem_address = res.mem_address;
  assign mem_write_data = res.mem_write_data;
endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed MIPS32 integer instructions into the execute
// unit, predicts each result word from a private register file and HI/LO
// copy, and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
import mieu_pkg::*;

typedef struct packed {
  logic [1:0]  status;
  logic        redirect;
  logic [31:0] redirect_target;
  logic [2:0]  mem_op;
  logic [31:0] mem_address;
  logic [31:0] mem_write_data;
} exec_word_t;

class exec_scoreboard;
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  logic [4:0]  ld_dest;
  logic [1:0]  ld_kind;
  exec_word_t  pending_q[$];
  int          mismatches;

  function new();
    foreach (gpr[i]) gpr[i] = '0;
    hi_q = '0;
    lo_q = '0;
    ld_dest = '0;
    ld_kind = LK_NONE;
    mismatches = 0;
  endfunction

  function void put_reg(logic [4:0] idx, logic [31:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endfunction

  function void note_instr(logic [5:0] f, logic [4:0] rsi, logic [4:0] rti, logic [4:0] rdi,
                           logic [4:0] sa, logic [15:0] imm, logic [25:0] tgt,
                           logic [31:0] pcv, logic [31:0] ld);
    logic [31:0] a, b, simm, s, q, r, ua, ub;
    logic signed [63:0] prod;
    logic take;
    exec_word_t w;
    a = gpr[rsi];
    b = gpr[rti];
    simm = {{16{imm[15]}}, imm};
    take = 1'b0;
    w = '0;
    case (f)
      OP_ADD: begin
        s = a + b;
        if ((a[31] == b[31]) && (s[31] != a[31])) w.status = ST_OVF; else put_reg(rdi, s);
      end
      OP_ADDI: begin
        s = a + simm;
        if ((a[31] == simm[31]) && (s[31] != a[31])) w.status = ST_OVF; else put_reg(rti, s);
      end
      OP_ADDIU: put_reg(rti, a + simm);
      OP_ADDU:  put_reg(rdi, a + b);
      OP_AND:   put_reg(rdi, a & b);
      OP_ANDI:  put_reg(rti, a & {16'd0, imm});
      OP_BEQ:   take = (a == b);
      OP_BGEZ:  take = !a[31];
      OP_BGTZ:  take = !a[31] && a != 0;
      OP_BLEZ:  take = a[31] || a == 0;
      OP_BLTZ:  take = a[31];
      OP_BNE:   take = (a != b);
      OP_BREAK: w.status = ST_BRK;
      OP_DIV: begin
        if (b != 0) begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub;
          r = ua % ub;
          lo_q = (a[31] != b[31]) ? -q : q;
          hi_q = a[31] ? -r : r;
        end
      end
      OP_J, OP_JAL: begin
        w.redirect = 1'b1;
        w.redirect_target = ((pcv + 32'd4) & PC_TOP_MASK) | {4'd0, tgt, 2'b00};
        if (f == OP_JAL) put_reg(5'd31, pcv + 32'd8);
      end
      OP_JALR: begin
        w.redirect = 1'b1;
        w.redirect_target = a;
        put_reg(rdi, pcv + 32'd8);
      end
      OP_JR: begin
        w.redirect = 1'b1;
        w.redirect_target = a;
      end
      OP_LB, OP_LBU, OP_LW: begin
        w.mem_op = (f == OP_LW) ? MEM_RW : MEM_RB;
        w.mem_address = a + simm;
        ld_dest = rti;
        ld_kind = (f == OP_LB) ? LK_LB : (f == OP_LBU) ? LK_LBU : LK_LW;
      end
      OP_LUI:  put_reg(rti, {imm, 16'd0});
      OP_MFHI: put_reg(rdi, hi_q);
      OP_MFLO: put_reg(rdi, lo_q);
      OP_MULT: begin
        prod = $signed(a) * $signed(b);
        lo_q = prod[31:0];
        hi_q = prod[63:32];
      end
      OP_OR:    put_reg(rdi, a | b);
      OP_ORI:   put_reg(rti, a | {16'd0, imm});
      OP_SB: begin
        w.mem_op = MEM_WB;
        w.mem_address = a + simm;
        w.mem_write_data = {24'd0, b[7:0]};
      end
      OP_SEB:   put_reg(rdi, {{24{b[7]}}, b[7:0]});
      OP_SLL:   put_reg(rdi, b << sa);
      OP_SLT:   put_reg(rdi, {31'd0, $signed(a) < $signed(b)});
      OP_SLTI:  put_reg(rti, {31'd0, $signed(a) < $signed(simm)});
      OP_SLTIU: put_reg(rti, {31'd0, a < simm});
      OP_SLTU:  put_reg(rdi, {31'd0, a < b});
      OP_SRA:   put_reg(rdi, $unsigned($signed(b) >>> sa));
      OP_SRL:   put_reg(rdi, b >> sa);
      OP_SUB: begin
        s = a - b;
        if ((a[31] != b[31]) && (s[31] != a[31])) w.status = ST_OVF; else put_reg(rdi, s);
      end
      OP_SUBU: put_reg(rdi, a - b);
      OP_SW: begin
        w.mem_op = MEM_WW;
        w.mem_address = a + simm;
        w.mem_write_data = b;
      end
      OP_XOR: put_reg(rdi, a ^ b);
      OP_LDRET: begin
        case (ld_kind)
          LK_LB:  put_reg(ld_dest, {{24{ld[7]}}, ld[7:0]});
          LK_LBU: put_reg(ld_dest, {24'd0, ld[7:0]});
          LK_LW:  put_reg(ld_dest, ld);
          default: ;
        endcase
        ld_kind = LK_NONE;
        ld_dest = '0;
      end
      default: ;
    endcase
    if (take) begin
      w.redirect = 1'b1;
      w.redirect_target = pcv + 32'd4 + (simm << 2);
    end
    pending_q.push_back(w);
  endfunction

  function void check_word(exec_word_t got);
    exec_word_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: st %0d/%0d rd %0d/%0d tgt %h/%h mop %0d/%0d addr %h/%h wd %h/%h",
                 want.status, got.status, want.redirect, got.redirect,
                 want.redirect_target, got.redirect_target, want.mem_op, got.mem_op,
                 want.mem_address, got.mem_address, want.mem_write_data,
                 got.mem_write_data);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1210;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  func = '0;
  logic [4:0]  rs_index = '0, rt_index = '0, rd_index = '0, shift_amount = '0;
  logic [15:0] immediate = '0;
  logic [25:0] jump_target = '0;
  logic [31:0] pc = '0, load_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        redirect;
  logic [31:0] redirect_target;
  logic [2:0]  mem_op;
  logic [31:0] mem_address, mem_write_data;

  exec_scoreboard sb;
  int  cycle_count = 0;
  bit  quiet_tail = 1'b0;

  mips_integer_execute_unit i_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sink: random stall bursts, none in the tail.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word({status, redirect, redirect_target, mem_op, mem_address, mem_write_data});
  end

  task automatic send_instr(logic [5:0] f, logic [4:0] rsi, logic [4:0] rti,
                            logic [4:0] rdi, logic [4:0] sa, logic [15:0] imm,
                            logic [25:0] tgt, logic [31:0] pcv, logic [31:0] ld);
    if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; rs_index <= rsi; rt_index <= rti; rd_index <= rdi;
    shift_amount <= sa; immediate <= imm; jump_target <= tgt; pc <= pcv; load_data <= ld;
    do @(posedge clk); while (!in_ready);
    sb.note_instr(f, rsi, rti, rdi, sa, imm, tgt, pcv, ld);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [5:0] f;
    logic [4:0] d, rsi, rti, rdi, sa;
    logic [15:0] imm;
    logic [25:0] tgt;
    logic [31:0] pcv, ld;
    d = 5'($urandom_range(0, 31));
    rsi = 5'($urandom);
    rti = 5'($urandom);
    rdi = 5'($urandom);
    sa = 5'($urandom);
    imm = 16'($urandom);
    tgt = 26'($urandom);
    pcv = $urandom;
    ld = $urandom;
    case ($urandom_range(0, 9))
      // seed a register with an interesting value via a load pair
      0: begin
        send_instr(OP_LW, rsi, d, rdi, sa, imm, tgt, pcv, ld);
        send_instr(OP_LDRET, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                   16'($urandom), 26'($urandom), $urandom, rand_word());
      end
      1: begin
        f = 6'($urandom_range(42, 63));
        send_instr(f, rsi, rti, rdi, sa, imm, tgt, pcv, ld);
      end
      default: begin
        f = 6'($urandom_range(0, 41));
        send_instr(f, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
                   5'($urandom_range(0, 7)), sa, imm, tgt, pcv, rand_word());
      end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, overflow, divide corners, pending-load cases
    send_instr(OP_LDRET, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_instr(OP_LUI, 0, 1, 0, 0, 16'h8000, 0, 0, 0);
    send_instr(OP_ADDIU, 0, 2, 0, 0, 16'hFFFF, 0, 0, 0);
    send_instr(OP_ADD, 1, 1, 3, 0, 0, 0, 0, 0);
    send_instr(OP_SUB, 1, 2, 3, 0, 0, 0, 0, 0);
    send_instr(OP_ADDI, 1, 4, 0, 0, 16'hFFFF, 0, 0, 0);
    send_instr(OP_DIV, 1, 2, 0, 0, 0, 0, 0, 0);
    send_instr(OP_MFLO, 0, 0, 5, 0, 0, 0, 0, 0);
    send_instr(OP_MFHI, 0, 0, 6, 0, 0, 0, 0, 0);
    send_instr(OP_DIV, 1, 0, 0, 0, 0, 0, 0, 0);
    send_instr(OP_MULT, 1, 1, 0, 0, 0, 0, 0, 0);
    send_instr(OP_MFHI, 0, 0, 7, 0, 0, 0, 0, 0);
    send_instr(OP_SRA, 0, 1, 8, 31, 0, 0, 0, 0);
    send_instr(OP_LB, 2, 9, 0, 0, 16'h7FFF, 0, 0, 0);
    send_instr(OP_LBU, 0, 10, 0, 0, 16'h8000, 0, 0, 0);
    send_instr(OP_LDRET, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0080);
    send_instr(OP_ADDU, 0, 0, 0, 0, 0, 0, 0, 32'h1);
    send_instr(OP_SW, 1, 2, 0, 0, 16'h0004, 0, 0, 0);
    send_instr(OP_SB, 1, 2, 0, 0, 16'hFFFC, 0, 0, 0);
    send_instr(OP_JAL, 0, 0, 0, 0, 0, 26'h3FF_FFFF, 32'hFFFF_FFFC, 0);
    send_instr(OP_JALR, 31, 0, 0, 0, 0, 0, 32'h1234_5678, 0);
    send_instr(OP_BGTZ, 2, 0, 0, 0, 16'h8000, 0, 32'h0000_1000, 0);
    send_instr(OP_BREAK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_instr(63, 31, 31, 31, 31, 16'hFFFF, 26'h3FF_FFFF, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 100) quiet_tail = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
